>>> sv/vic_pkg.sv
// Package for the 16-channel vectored interrupt controller.
// Holds the action codes, register select codes and the transaction and state types.
// No dependencies.
package vic_pkg;

    localparam int CHANNELS = 16;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_EVENT = 2'd2,
        ACT_ACK   = 2'd3
    } action_t;

    localparam logic [3:0] REG_IERA = 4'd0;
    localparam logic [3:0] REG_IERB = 4'd1;
    localparam logic [3:0] REG_IPRA = 4'd2;
    localparam logic [3:0] REG_IPRB = 4'd3;
    localparam logic [3:0] REG_ISRA = 4'd4;
    localparam logic [3:0] REG_ISRB = 4'd5;
    localparam logic [3:0] REG_IMRA = 4'd6;
    localparam logic [3:0] REG_IMRB = 4'd7;
    localparam logic [3:0] REG_VR   = 4'd8;

    typedef struct packed {
        action_t     action;
        logic [3:0]  reg_select;
        logic [7:0]  write_data;
        logic [3:0]  channel;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [7:0]  vector;
        logic        spurious;
        logic        irq;
    } result_t;

    typedef struct packed {
        logic [CHANNELS-1:0] enable_bits;
        logic [CHANNELS-1:0] pending_bits;
        logic [CHANNELS-1:0] service_bits;
        logic [CHANNELS-1:0] mask_bits;
        logic [3:0]          vector_base;
        logic                service_enable;
    } state_t;

endpackage

>>> sv/vic_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on vic_pkg.
interface vic_req_if;
    logic               valid;
    logic               ready;
    vic_pkg::action_t   action;
    logic [3:0]         reg_select;
    logic [7:0]         write_data;
    logic [3:0]         channel;

    modport source (output valid, action, reg_select, write_data, channel, input ready);
    modport sink   (input valid, action, reg_select, write_data, channel, output ready);
endinterface

interface vic_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [7:0]  vector;
    logic        spurious;
    logic        irq;

    modport source (output valid, read_data, vector, spurious, irq, input ready);
    modport sink   (input valid, read_data, vector, spurious, irq, output ready);
endinterface

>>> sv/vectored_interrupt_controller_16ch.sv
// 16-channel vectored interrupt controller, top level.
// A request transaction passes through the input register, then the result register;
// throughput is one transaction per cycle while the output is not stalled, with the
// state update done combinationally in vic_core. Output stalls back up through the input register.
// Reset (rst_n, asynchronous) clears all enable, pending, in-service, mask and vector bits.
module vectored_interrupt_controller_16ch (
    input  logic       clk,
    input  logic       rst_n,
    vic_req_if.sink    req,
    vic_rsp_if.source  rsp
);
    import vic_pkg::*;

    item_t   req_reg;
    logic    req_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t rsp_reg;
    result_t rsp_next;
    logic    rsp_valid_reg;
    logic    advance;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = !req_valid_reg || advance;

    vic_core u_core (
        .st      (state_reg),
        .item    (req_reg),
        .st_next (state_next),
        .res     (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                req_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
            if (req_valid_reg && advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg.action     <= req.action;
            req_reg.reg_select <= req.reg_select;
            req_reg.write_data <= req.write_data;
            req_reg.channel    <= req.channel;
        end
        if (req_valid_reg && advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_reg.read_data;
    assign rsp.vector    = rsp_reg.vector;
    assign rsp.spurious  = rsp_reg.spurious;
    assign rsp.irq       = rsp_reg.irq;

endmodule

>>> sv/vic_core.sv
// Combinational step of the interrupt controller: register access, channel events,
// priority acknowledge and irq evaluation. Depends on vic_pkg.
module vic_core (
    input  vic_pkg::state_t  st,
    input  vic_pkg::item_t   item,
    output vic_pkg::state_t  st_next,
    output vic_pkg::result_t res
);
    import vic_pkg::*;

    logic [CHANNELS-1:0] eligible;
    logic [CHANNELS-1:0] candidates;
    logic                found;
    logic [3:0]          win;

    // channel k lies above the highest in-service bit
    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            eligible[k] = ~|(st.service_bits >> k);
        end
        candidates = eligible & st.pending_bits & st.mask_bits;
        found = |candidates;
        win = '0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            if (candidates[k])
            begin
                win = 4'(k);
            end
        end
    end

    always_comb
    begin
        st_next = st;
        res = '0;
        case (item.action)
            ACT_WRITE:
            begin
                case (item.reg_select)
                    REG_IERA:
                    begin
                        st_next.enable_bits[15:8] = item.write_data;
                        st_next.pending_bits = st.pending_bits & st_next.enable_bits;
                    end
                    REG_IERB:
                    begin
                        st_next.enable_bits[7:0] = item.write_data;
                        st_next.pending_bits = st.pending_bits & st_next.enable_bits;
                    end
                    REG_IPRA: st_next.pending_bits[15:8] = item.write_data;
                    REG_IPRB: st_next.pending_bits[7:0]  = item.write_data;
                    REG_ISRA: st_next.service_bits[15:8] = item.write_data;
                    REG_ISRB: st_next.service_bits[7:0]  = item.write_data;
                    REG_IMRA: st_next.mask_bits[15:8]    = item.write_data;
                    REG_IMRB: st_next.mask_bits[7:0]     = item.write_data;
                    REG_VR:
                    begin
                        st_next.vector_base = item.write_data[7:4];
                        st_next.service_enable = item.write_data[3];
                        if (st.service_enable && !item.write_data[3])
                        begin
                            st_next.service_bits = '0;
                        end
                    end
                    default: ;
                endcase
            end
            ACT_READ:
            begin
                case (item.reg_select)
                    REG_IERA: res.read_data = st.enable_bits[15:8];
                    REG_IERB: res.read_data = st.enable_bits[7:0];
                    REG_IPRA: res.read_data = st.pending_bits[15:8];
                    REG_IPRB: res.read_data = st.pending_bits[7:0];
                    REG_ISRA: res.read_data = st.service_bits[15:8];
                    REG_ISRB: res.read_data = st.service_bits[7:0];
                    REG_IMRA: res.read_data = st.mask_bits[15:8];
                    REG_IMRB: res.read_data = st.mask_bits[7:0];
                    REG_VR:   res.read_data = {st.vector_base, st.service_enable, 3'b000};
                    default:  res.read_data = '0;
                endcase
            end
            ACT_EVENT:
            begin
                if (st.enable_bits[item.channel])
                begin
                    st_next.pending_bits[item.channel] = 1'b1;
                end
            end
            ACT_ACK:
            begin
                if (found)
                begin
                    st_next.pending_bits[win] = 1'b0;
                    if (st.service_enable)
                    begin
                        st_next.service_bits[win] = 1'b1;
                    end
                    res.vector = {st.vector_base, win};
                end
                else
                begin
                    res.spurious = 1'b1;
                end
            end
            default: ;
        endcase
        res.irq = (st_next.pending_bits & st_next.mask_bits) > st_next.service_bits;
    end

endmodule

>>> sv/vic_checker.sv
// Port-level checker for the interrupt controller, with its bind to the top level.
// Depends on vectored_interrupt_controller_16ch and vic_if.
module vic_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] read_data,
    input logic [7:0] vector,
    input logic       spurious
);

    // response transaction holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // every accepted request finds rsp_valid set once it has passed the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##2 rsp_valid)
        else $error("response missing two cycles after request");

    a_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && spurious |-> vector == 8'd0 && read_data == 8'd0)
        else $error("spurious acknowledge carries data");

    a_vector: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && vector != 8'd0 |-> read_data == 8'd0)
        else $error("vector and read data both set");

endmodule

bind vectored_interrupt_controller_16ch vic_checker u_vic_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .read_data (rsp.read_data),
    .vector    (rsp.vector),
    .spurious  (rsp.spurious)
);
